/* sv/gtb_pkg.sv */
package gtb_pkg;

   // Block dimensions
   localparam int WINDOW_LEN = 256;
   localparam int HOP_LEN    = 64;
   localparam int TONE_COUNT = 32;

   localparam int WIN_W  = $clog2(WINDOW_LEN);
   localparam int HOP_W  = $clog2(HOP_LEN + 1);
   localparam int TONE_W = $clog2(TONE_COUNT);

   // Field widths
   localparam int SAMPLE_W   = 16;
   localparam int SELECT_W   = 5;
   localparam int COEF_W     = 17;
   localparam int TONE_NUM_W = 5;
   localparam int ENERGY_W   = 50;

   // Datapath widths
   localparam int ROM_W     = 16;
   localparam int HANN_FRAC = 15;
   localparam int COEF_FRAC = 14;
   localparam int STATE_W   = 32;
   localparam int PROD_W    = COEF_W + STATE_W;
   localparam int MULT_A_W  = PROD_W - COEF_FRAC;
   localparam int MULT_P_W  = MULT_A_W + STATE_W;
   localparam int ACC_W     = MULT_P_W + 1;

   // Commands
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   // Coefficient bounds, +-2.0 in Q14
   localparam logic signed [COEF_W-1:0] COEF_MAX = 17'sd32768;
   localparam logic signed [COEF_W-1:0] COEF_MIN = -17'sd32768;

   typedef struct packed {
      logic                       valid;
      logic                       first;
      logic                       last;
      logic signed [SAMPLE_W-1:0] xw;
   } tap_type;

   typedef struct packed {
      logic signed [COEF_W-1:0]  coef;
      logic signed [STATE_W-1:0] s1;
      logic signed [STATE_W-1:0] s2;
   } cell_state_type;

   typedef logic [WINDOW_LEN-1:0][ROM_W-1:0] hann_rom_type;

   // Hann table, built at elaboration with exact integer math (Q60)
   localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
   localparam logic [63:0] PI_STEP  = PI_Q60 / 64'(WINDOW_LEN);
   localparam logic [63:0] PI_REM   = PI_Q60 % 64'(WINDOW_LEN);
   localparam logic [63:0] HANN_MID = 64'd16384;
   localparam logic [63:0] HANN_TOP = 64'd32767;

   function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[123:60];
   endfunction

   // Taylor series of sin(x), 0 <= x <= pi/2
   function automatic logic [63:0] sine_q60(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] sum;
      logic [63:0] term;
      x2   = mul_q60(x, x);
      sum  = x;
      term = x;
      term = mul_q60(term, x2) / 64'd6;    sum = sum - term;
      term = mul_q60(term, x2) / 64'd20;   sum = sum + term;
      term = mul_q60(term, x2) / 64'd42;   sum = sum - term;
      term = mul_q60(term, x2) / 64'd72;   sum = sum + term;
      term = mul_q60(term, x2) / 64'd110;  sum = sum - term;
      term = mul_q60(term, x2) / 64'd156;  sum = sum + term;
      term = mul_q60(term, x2) / 64'd210;  sum = sum - term;
      term = mul_q60(term, x2) / 64'd272;  sum = sum + term;
      term = mul_q60(term, x2) / 64'd342;  sum = sum - term;
      term = mul_q60(term, x2) / 64'd420;  sum = sum + term;
      term = mul_q60(term, x2) / 64'd506;  sum = sum - term;
      term = mul_q60(term, x2) / 64'd600;  sum = sum + term;
      term = mul_q60(term, x2) / 64'd702;  sum = sum - term;
      term = mul_q60(term, x2) / 64'd812;  sum = sum + term;
      term = mul_q60(term, x2) / 64'd930;  sum = sum - term;
      term = mul_q60(term, x2) / 64'd1056; sum = sum + term;
      return sum;
   endfunction

   // 0.5 - 0.5cos(2a) = sin(a)^2, a = pi*m/WINDOW_LEN, rounded half up
   function automatic logic [ROM_W-1:0] hann_entry(input int unsigned n);
      logic [63:0] m;
      logic [63:0] x;
      logic [63:0] s;
      logic [63:0] sq;
      logic [63:0] v;
      m = 64'(n);
      if ((m << 1) > 64'(WINDOW_LEN)) m = 64'(WINDOW_LEN) - m;
      if ((m << 2) == 64'(WINDOW_LEN)) return HANN_MID[ROM_W-1:0];
      x  = PI_STEP * m + (PI_REM * m) / WINDOW_LEN;
      s  = sine_q60(x);
      sq = mul_q60(s, s);
      v  = ((sq >> 20) * HANN_TOP + (64'd1 << 39)) >> 40;
      if (v > HANN_TOP) v = HANN_TOP;
      return v[ROM_W-1:0];
   endfunction

   function automatic hann_rom_type hann_rom_build();
      hann_rom_type rom;
      for (int unsigned n = 0; n < WINDOW_LEN; n++) begin
         rom[n] = hann_entry(n);
      end
      return rom;
   endfunction

   localparam hann_rom_type HANN_ROM = hann_rom_build();

endpackage

/* sv/gtb_if.sv */
interface gtb_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 command;
   logic signed [gtb_pkg::SAMPLE_W-1:0]  sample;
   logic        [gtb_pkg::SELECT_W-1:0]  tone_select;
   logic signed [gtb_pkg::COEF_W-1:0]    tone_coefficient;

   modport source (output valid, command, sample, tone_select, tone_coefficient,
                   input ready);
   modport sink (input valid, command, sample, tone_select, tone_coefficient,
                 output ready);
endinterface

interface gtb_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [gtb_pkg::TONE_NUM_W-1:0]    tone_number;
   logic [gtb_pkg::ENERGY_W-1:0]      tone_energy;
   logic                              last_tone;

   modport source (output valid, tone_number, tone_energy, last_tone, input ready);
   modport sink (input valid, tone_number, tone_energy, last_tone, output ready);
endinterface

/* sv/gtb_feed.sv */
// Sample ring, hop counter and windowing front end of the cell chain.
module gtb_feed (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  logic signed [gtb_pkg::SAMPLE_W-1:0] push_sample,
   output logic                                clearing,
   output logic                                frame_start,
   output gtb_pkg::tap_type                    tap_out
);

   logic signed [gtb_pkg::SAMPLE_W-1:0] ring [gtb_pkg::WINDOW_LEN];

   logic                          clear_ff, clear_in;
   logic [gtb_pkg::WIN_W-1:0]     clr_addr_ff, clr_addr_in;
   logic [gtb_pkg::WIN_W-1:0]     wp_ff, wp_in;
   logic [gtb_pkg::HOP_W-1:0]     hop_ff, hop_in;
   logic                          sweep_ff, sweep_in;
   logic [gtb_pkg::WIN_W-1:0]     idx_ff, idx_in;

   // read stage
   logic                          st1_valid_ff;
   logic                          st1_first_ff;
   logic                          st1_last_ff;
   logic [gtb_pkg::WIN_W-1:0]     st1_idx_ff;
   logic signed [gtb_pkg::SAMPLE_W-1:0] rd_data_ff;

   // window product stage
   logic                          st2_valid_ff;
   logic                          st2_first_ff;
   logic                          st2_last_ff;
   logic signed [2*gtb_pkg::SAMPLE_W-1:0] wprod_ff;

   gtb_pkg::tap_type              tap_ff, tap_in;

   logic                          last_slot;
   logic [gtb_pkg::WIN_W:0]       addr_sum;
   logic [gtb_pkg::WIN_W-1:0]     rd_addr;
   logic [gtb_pkg::WIN_W-1:0]     wp_inc;
   logic signed [gtb_pkg::ROM_W-1:0] rom_val;

   assign last_slot   = (idx_ff == gtb_pkg::WIN_W'(gtb_pkg::WINDOW_LEN - 1));
   assign frame_start = push && (hop_ff == gtb_pkg::HOP_W'(gtb_pkg::HOP_LEN - 1));
   assign wp_inc      = (wp_ff == gtb_pkg::WIN_W'(gtb_pkg::WINDOW_LEN - 1)) ?
                        '0 : wp_ff + 1'b1;
   // oldest sample sits at the write pointer
   assign addr_sum    = {1'b0, wp_ff} + {1'b0, idx_ff};
   assign rd_addr     = (addr_sum >= (gtb_pkg::WIN_W+1)'(gtb_pkg::WINDOW_LEN)) ?
                        gtb_pkg::WIN_W'(addr_sum - (gtb_pkg::WIN_W+1)'(gtb_pkg::WINDOW_LEN)) :
                        addr_sum[gtb_pkg::WIN_W-1:0];
   assign rom_val     = gtb_pkg::HANN_ROM[st1_idx_ff];
   assign clearing    = clear_ff;
   assign tap_out     = tap_ff;

   always_comb begin
      clear_in    = clear_ff;
      clr_addr_in = clr_addr_ff;
      wp_in       = wp_ff;
      hop_in      = hop_ff;
      sweep_in    = sweep_ff;
      idx_in      = idx_ff;
      if (clear_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == gtb_pkg::WIN_W'(gtb_pkg::WINDOW_LEN - 1)) begin
            clear_in = 1'b0;
         end
      end
      if (push) begin
         wp_in  = wp_inc;
         hop_in = frame_start ? '0 : hop_ff + 1'b1;
      end
      if (frame_start) begin
         sweep_in = 1'b1;
         idx_in   = '0;
      end else if (sweep_ff) begin
         idx_in = idx_ff + 1'b1;
         if (last_slot) begin
            sweep_in = 1'b0;
         end
      end
      tap_in.valid = st2_valid_ff;
      tap_in.first = st2_first_ff;
      tap_in.last  = st2_last_ff;
      tap_in.xw    = wprod_ff[gtb_pkg::HANN_FRAC+gtb_pkg::SAMPLE_W-1:gtb_pkg::HANN_FRAC];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clr_addr_ff  <= '0;
         wp_ff        <= '0;
         hop_ff       <= '0;
         sweep_ff     <= 1'b0;
         idx_ff       <= '0;
         st1_valid_ff <= 1'b0;
         st2_valid_ff <= 1'b0;
         tap_ff       <= '0;
      end else begin
         clear_ff     <= clear_in;
         clr_addr_ff  <= clr_addr_in;
         wp_ff        <= wp_in;
         hop_ff       <= hop_in;
         sweep_ff     <= sweep_in;
         idx_ff       <= idx_in;
         st1_valid_ff <= sweep_ff;
         st2_valid_ff <= st1_valid_ff;
         tap_ff       <= tap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clear_ff) begin
         ring[clr_addr_ff] <= '0;
      end else if (push) begin
         ring[wp_ff] <= push_sample;
      end
      rd_data_ff   <= ring[rd_addr];
      st1_first_ff <= (idx_ff == '0);
      st1_last_ff  <= last_slot;
      st1_idx_ff   <= idx_ff;
      st2_first_ff <= st1_first_ff;
      st2_last_ff  <= st1_last_ff;
      wprod_ff     <= rd_data_ff * rom_val;
   end

endmodule

/* sv/gtb_cell.sv */
// One Goertzel recurrence; windowed samples pass through to the next cell.
module gtb_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  gtb_pkg::tap_type                  tap_in,
   input  logic                              coef_we,
   input  logic signed [gtb_pkg::COEF_W-1:0] coef_in,
   output gtb_pkg::tap_type                  tap_out,
   output gtb_pkg::cell_state_type           state_out
);

   gtb_pkg::tap_type                   tap_ff;
   logic signed [gtb_pkg::COEF_W-1:0]  coef_ff, coef_in_sel;
   logic signed [gtb_pkg::STATE_W-1:0] s1_ff, s1_in;
   logic signed [gtb_pkg::STATE_W-1:0] s2_ff, s2_in;

   logic signed [gtb_pkg::SAMPLE_W-1:0] xw;
   logic signed [gtb_pkg::STATE_W-1:0]  s1_use, s2_use;
   logic signed [gtb_pkg::PROD_W-1:0]   prod;
   logic signed [gtb_pkg::MULT_A_W-1:0] fb;
   logic signed [gtb_pkg::STATE_W+3:0]  s0_wide;

   assign xw     = tap_in.xw;
   // frame start: recurrence begins from zero state
   assign s1_use = tap_in.first ? '0 : s1_ff;
   assign s2_use = tap_in.first ? '0 : s2_ff;
   assign prod   = coef_ff * s1_use;
   assign fb     = prod[gtb_pkg::PROD_W-1:gtb_pkg::COEF_FRAC];
   assign s0_wide = (gtb_pkg::STATE_W+4)'(xw) + (gtb_pkg::STATE_W+4)'(fb)
                  - (gtb_pkg::STATE_W+4)'(s2_use);

   assign coef_in_sel = coef_we ? coef_in : coef_ff;
   assign s1_in = tap_in.valid ? s0_wide[gtb_pkg::STATE_W-1:0] : s1_ff;
   assign s2_in = tap_in.valid ? s1_use : s2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff  <= '0;
         coef_ff <= '0;
      end else begin
         tap_ff  <= tap_in;
         coef_ff <= coef_in_sel;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
   end

   assign tap_out         = tap_ff;
   assign state_out.coef  = coef_ff;
   assign state_out.s1    = s1_ff;
   assign state_out.s2    = s2_ff;

endmodule

/* sv/gtb_power.sv */
// Shared power unit: s1^2 + s2^2 - ((c*s1)>>14)*s2 over five steps per tone.
module gtb_power (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  gtb_pkg::cell_state_type       tone_state,
   output logic [gtb_pkg::TONE_W-1:0]    tone_sel,
   output logic                          busy,
   gtb_rsp_if.source                     rsp_chan
);

   localparam logic [2:0] STEP_SQ1 = 3'd0;
   localparam logic [2:0] STEP_SQ2 = 3'd1;
   localparam logic [2:0] STEP_CS  = 3'd2;
   localparam logic [2:0] STEP_PS  = 3'd3;
   localparam logic [2:0] STEP_OUT = 3'd4;

   logic                                 active_ff, active_in;
   logic [2:0]                           step_ff, step_in;
   logic [gtb_pkg::TONE_W-1:0]           tone_ff, tone_in;
   logic signed [gtb_pkg::MULT_P_W-1:0]  prod_ff;
   logic signed [gtb_pkg::ACC_W-1:0]     acc_ff, acc_in;
   logic                                 out_valid_ff, out_valid_in;
   logic [gtb_pkg::TONE_NUM_W-1:0]       out_tone_ff;
   logic [gtb_pkg::ENERGY_W-1:0]         out_energy_ff;
   logic                                 out_last_ff;

   logic signed [gtb_pkg::STATE_W-1:0]   st_s1, st_s2;
   logic signed [gtb_pkg::COEF_W-1:0]    st_coef;
   logic signed [gtb_pkg::MULT_A_W-1:0]  op_a;
   logic signed [gtb_pkg::STATE_W-1:0]   op_b;
   logic signed [gtb_pkg::MULT_P_W-1:0]  mult;
   logic signed [gtb_pkg::ACC_W-1:0]     total;
   logic [gtb_pkg::ENERGY_W-1:0]         energy;
   logic                                 tone_last;
   logic                                 out_free;
   logic                                 out_load;

   assign st_s1   = tone_state.s1;
   assign st_s2   = tone_state.s2;
   assign st_coef = tone_state.coef;

   always_comb begin
      case (step_ff)
         STEP_SQ1: begin
            op_a = gtb_pkg::MULT_A_W'(st_s1);
            op_b = st_s1;
         end
         STEP_SQ2: begin
            op_a = gtb_pkg::MULT_A_W'(st_s2);
            op_b = st_s2;
         end
         STEP_CS: begin
            op_a = gtb_pkg::MULT_A_W'(st_coef);
            op_b = st_s1;
         end
         STEP_PS: begin
            // (c*s1) >> 14 taken straight from the product register
            op_a = prod_ff[gtb_pkg::PROD_W-1:gtb_pkg::COEF_FRAC];
            op_b = st_s2;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign mult      = op_a * op_b;
   assign total     = acc_ff - gtb_pkg::ACC_W'(prod_ff);
   assign tone_last = (tone_ff == gtb_pkg::TONE_W'(gtb_pkg::TONE_COUNT - 1));
   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign out_load  = active_ff && (step_ff == STEP_OUT) && out_free;

   always_comb begin
      if (total[gtb_pkg::ACC_W-1]) begin
         energy = '0;
      end else if (|total[gtb_pkg::ACC_W-2:gtb_pkg::ENERGY_W]) begin
         energy = '1;
      end else begin
         energy = total[gtb_pkg::ENERGY_W-1:0];
      end
   end

   always_comb begin
      active_in    = active_ff;
      step_in      = step_ff;
      tone_in      = tone_ff;
      acc_in       = acc_ff;
      out_valid_in = out_valid_ff;
      if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (start) begin
         active_in = 1'b1;
         step_in   = STEP_SQ1;
         tone_in   = '0;
      end else if (active_ff) begin
         case (step_ff)
            STEP_SQ1: step_in = STEP_SQ2;
            STEP_SQ2: begin
               step_in = STEP_CS;
               acc_in  = gtb_pkg::ACC_W'(prod_ff);
            end
            STEP_CS: begin
               step_in = STEP_PS;
               acc_in  = acc_ff + gtb_pkg::ACC_W'(prod_ff);
            end
            STEP_PS: step_in = STEP_OUT;
            STEP_OUT: begin
               if (out_free) begin
                  out_valid_in = 1'b1;
                  step_in      = STEP_SQ1;
                  if (tone_last) begin
                     active_in = 1'b0;
                  end else begin
                     tone_in = tone_ff + 1'b1;
                  end
               end
            end
            default: step_in = STEP_SQ1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         step_ff      <= STEP_SQ1;
         tone_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         step_ff      <= step_in;
         tone_ff      <= tone_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (step_ff != STEP_OUT) begin
         prod_ff <= mult;
      end
      if (out_load) begin
         out_tone_ff   <= gtb_pkg::TONE_NUM_W'(tone_ff);
         out_energy_ff <= energy;
         out_last_ff   <= tone_last;
      end
   end

   // the last result may wait in the output register without holding off req
   assign tone_sel             = tone_ff;
   assign busy                 = active_ff;
   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.tone_number = out_tone_ff;
   assign rsp_chan.tone_energy = out_energy_ff;
   assign rsp_chan.last_tone   = out_last_ff;

endmodule

/* sv/goertzel_tone_bank_core.sv */
// Goertzel tone bank. Each req item either pushes one 16-bit audio sample
// into a 256-entry ring or loads the Q14 coefficient of one of 32 tones
// (saturated to +-2.0; a tone index past the bank is ignored). Every 64th
// pushed sample starts a frame: the ring is read oldest first, each sample
// is scaled by a Hann ROM entry and shifted right by 15, and the windowed
// stream walks down a row of 32 cells, one tone recurrence per cell, one
// sample per cycle. The cells' final states then go through one shared
// power unit, and the frame comes out as 32 rsp items (tones 0..31,
// last_tone set on tone 31) holding s1^2 + s2^2 - ((c*s1)>>14)*s2, clamped
// to [0, 2^50-1]. A load or a push that does not end a hop leaves
// req.ready high. A frame keeps req.ready low through the window sweep
// and chain drain (one ring read per cycle) and then through the power
// unit (one multiplier, five steps per tone). A stalled rsp lengthens
// this while tones 0..30 wait; the last result waits in the output
// register with req.ready already back high. After reset the ring is
// zeroed one entry per cycle, with req.ready held low.
module goertzel_tone_bank_core (
   input  logic      clock,
   input  logic      reset,
   gtb_req_if.sink   req_chan,
   gtb_rsp_if.source rsp_chan
);

   logic                                run_ff, run_in;
   logic                                accept;
   logic                                push;
   logic                                load;
   logic                                clearing;
   logic                                frame_start;
   logic                                chain_done;
   logic                                power_busy;
   logic signed [gtb_pkg::COEF_W-1:0]   coef_raw;
   logic signed [gtb_pkg::COEF_W-1:0]   coef_sat;
   logic [gtb_pkg::TONE_COUNT-1:0]      coef_we;
   logic [gtb_pkg::TONE_W-1:0]          tone_sel;
   gtb_pkg::tap_type                    taps [gtb_pkg::TONE_COUNT+1];
   gtb_pkg::cell_state_type             states [gtb_pkg::TONE_COUNT];

   // Items are taken only while no frame is in flight and the ring is ready.
   assign req_chan.ready = !clearing && !run_ff && !power_busy;
   assign accept = req_chan.valid && req_chan.ready;
   assign push   = accept && (req_chan.command == gtb_pkg::CMD_PUSH);
   assign load   = accept && (req_chan.command == gtb_pkg::CMD_LOAD);

   // Coefficient saturation to +-2.0
   assign coef_raw = req_chan.tone_coefficient;
   always_comb begin
      if (coef_raw > gtb_pkg::COEF_MAX) begin
         coef_sat = gtb_pkg::COEF_MAX;
      end else if (coef_raw < gtb_pkg::COEF_MIN) begin
         coef_sat = gtb_pkg::COEF_MIN;
      end else begin
         coef_sat = coef_raw;
      end
   end

   // Frame runs from the hop-ending push until the last windowed sample
   // leaves the final cell; that same cycle hands over to the power unit.
   assign chain_done = taps[gtb_pkg::TONE_COUNT].valid && taps[gtb_pkg::TONE_COUNT].last;

   always_comb begin
      run_in = run_ff;
      if (frame_start) begin
         run_in = 1'b1;
      end else if (chain_done) begin
         run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
   end

   gtb_feed u_feed (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_sample (req_chan.sample),
      .clearing    (clearing),
      .frame_start (frame_start),
      .tap_out     (taps[0])
   );

   // Row of tone cells: each cell passes the windowed samples on to the next through its tap register.
   for (genvar t = 0; t < gtb_pkg::TONE_COUNT; t++) begin : g_cell
      assign coef_we[t] = load && (req_chan.tone_select == gtb_pkg::SELECT_W'(t));

      gtb_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .tap_in    (taps[t]),
         .coef_we   (coef_we[t]),
         .coef_in   (coef_sat),
         .tap_out   (taps[t+1]),
         .state_out (states[t])
      );
   end

   gtb_power u_power (
      .clock      (clock),
      .reset      (reset),
      .start      (chain_done),
      .tone_state (states[tone_sel]),
      .tone_sel   (tone_sel),
      .busy       (power_busy),
      .rsp_chan   (rsp_chan)
   );

endmodule

/* sv/gtb_checker.sv */
module gtb_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [gtb_pkg::TONE_NUM_W-1:0]   rsp_tone_number,
   input logic [gtb_pkg::ENERGY_W-1:0]     rsp_tone_energy,
   input logic                             rsp_last_tone
);

   // ring clearing pass holds off input right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("req ready high during ring clear");

   // no input taken while the rest of a frame is still being reported
   a_no_accept_in_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_tone) |-> !req_ready)
      else $error("req ready while frame results pending");

   a_last_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_tone ==
                     (rsp_tone_number == gtb_pkg::TONE_NUM_W'(gtb_pkg::TONE_COUNT - 1))))
      else $error("last_tone does not match final tone");

   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !rsp_valid) |=> !rsp_valid)
      else $error("result right after accepted item");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_tone_number) &&
                                     $stable(rsp_tone_energy) && $stable(rsp_last_tone)))
      else $error("stalled result changed");

endmodule

bind goertzel_tone_bank_core gtb_checker u_gtb_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_tone_number (rsp_chan.tone_number),
   .rsp_tone_energy (rsp_chan.tone_energy),
   .rsp_last_tone   (rsp_chan.last_tone)
);
